// File: design/skt_pkg.sv
// shared types, field widths, opcodes and status codes for the sorted key table
package skt_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int KEY_W_DEF    = 32;

    localparam int OPC_W    = 3;
    localparam int KEY_IN_W = 32;
    localparam int POS_W    = 8;
    localparam int STAT_W   = 3;
    localparam int IDX_W    = 9;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    localparam logic [OPC_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OPC_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OPC_W-1:0] OP_SEARCH = 3'd2;
    localparam logic [OPC_W-1:0] OP_READ   = 3'd3;
    localparam logic [OPC_W-1:0] OP_REMOVE = 3'd4;
    localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd3;
    localparam logic [STAT_W-1:0] ST_DUP       = 3'd4;

    typedef struct packed {
        logic [OPC_W-1:0]    op;
        logic [KEY_IN_W-1:0] key;
        logic [POS_W-1:0]    pos;
        logic                dup;
    } skt_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic                found;
        logic [IDX_W-1:0]    index;
        logic [KEY_IN_W-1:0] rkey;
        logic [IDX_W-1:0]    count;
    } skt_res_t;

endpackage

// File: design/skt_mem.sv
// simple dual-port key memory with registered read data
module skt_mem #(
    parameter int DEPTH = skt_pkg::CAPACITY_DEF,
    parameter int WIDTH = skt_pkg::KEY_W_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= ram_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/skt_ctrl.sv
// sequencer: binary search, shift passes and count keeping over the key memory
module skt_ctrl #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF,
    parameter int KEY_W    = skt_pkg::KEY_W_DEF,
    localparam int AW   = $clog2(CAPACITY),
    localparam int SK_W = (KEY_W < skt_pkg::KEY_IN_W) ? KEY_W : skt_pkg::KEY_IN_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_valid,
    input  skt_pkg::skt_item_t item,
    output logic               item_ready,
    output logic               res_valid,
    output skt_pkg::skt_res_t  res,
    input  logic               res_ready,
    output logic               mem_wr_en,
    output logic [AW-1:0]      mem_wr_addr,
    output logic [SK_W-1:0]    mem_wr_data,
    output logic [AW-1:0]      mem_rd_addr,
    input  logic [SK_W-1:0]    mem_rd_data
);

    import skt_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int PC_W = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SRD   = 7'b0000010,
        S_SCMP  = 7'b0000100,
        S_RDW   = 7'b0001000,
        S_SHIFT = 7'b0010000,
        S_PUT   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [OPC_W-1:0]  op_reg, op_next;
    logic [SK_W-1:0]   key_reg, key_next;
    logic              dup_reg, dup_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     lo_reg, lo_next;
    logic [CW-1:0]     hip_reg, hip_next;
    logic [CW-1:0]     mid_reg, mid_next;
    logic              hit_reg, hit_next;
    logic              ins_reg, ins_next;
    logic [CW-1:0]     ix_reg, ix_next;
    logic [CW-1:0]     rp_reg, rp_next;
    logic              rd_act_reg, rd_act_next;
    logic              pend_reg, pend_next;
    logic [CW-1:0]     pend_addr_reg, pend_addr_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              found_reg, found_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [SK_W-1:0]   rkey_reg, rkey_next;

    logic          go_ins, go_rem;
    logic [CW-1:0] tgt;
    logic [CW-1:0] mid;
    logic          pos_ok;

    assign pos_ok = PC_W'(item.pos) < PC_W'(count_reg);
    // midpoint of lo..hi with hi kept as hi + 1
    assign mid = lo_reg + ((hip_reg - lo_reg - 1'b1) >> 1);

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        dup_next       = dup_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hip_next       = hip_reg;
        mid_next       = mid_reg;
        hit_next       = hit_reg;
        ins_next       = ins_reg;
        ix_next        = ix_reg;
        rp_next        = rp_reg;
        rd_act_next    = rd_act_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        idx_next       = idx_reg;
        rkey_next      = rkey_reg;
        go_ins         = 1'b0;
        go_rem         = 1'b0;
        tgt            = '0;
        item_ready     = 1'b0;
        res_valid      = 1'b0;
        mem_rd_addr    = rp_reg[AW-1:0];

        case (state_reg)
            S_IDLE: begin
                item_ready = 1'b1;
                if (item_valid) begin
                    op_next     = item.op;
                    key_next    = item.key[SK_W-1:0];
                    dup_next    = item.dup;
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    idx_next    = '0;
                    rkey_next   = '0;
                    lo_next     = '0;
                    hip_next    = count_reg;
                    hit_next    = 1'b0;
                    case (item.op)
                        OP_ADD: begin
                            if (count_reg == '0) begin
                                go_ins = 1'b1;
                            end else begin
                                state_next = S_SRD;
                            end
                        end
                        OP_DELETE, OP_SEARCH: begin
                            state_next = S_SRD;
                        end
                        OP_READ: begin
                            if (pos_ok) begin
                                mem_rd_addr = AW'(item.pos);
                                idx_next    = CW'(item.pos);
                                state_next  = S_RDW;
                            end else begin
                                status_next = ST_BAD_INDEX;
                                state_next  = S_DONE;
                            end
                        end
                        OP_REMOVE: begin
                            if (pos_ok) begin
                                idx_next = CW'(item.pos);
                                tgt      = CW'(item.pos);
                                go_rem   = 1'b1;
                            end else begin
                                status_next = ST_BAD_INDEX;
                                state_next  = S_DONE;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SRD: begin
                if (!hit_reg && (lo_reg < hip_reg)) begin
                    mid_next    = mid;
                    mem_rd_addr = mid[AW-1:0];
                    state_next  = S_SCMP;
                end else begin
                    found_next = hit_reg;
                    idx_next   = lo_reg;
                    case (op_reg)
                        OP_ADD: begin
                            if (hit_reg && !dup_reg) begin
                                status_next = ST_DUP;
                                state_next  = S_DONE;
                            end else if (count_reg >= CW'(CAPACITY)) begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end else begin
                                tgt    = lo_reg;
                                go_ins = 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            if (hit_reg) begin
                                tgt    = lo_reg;
                                go_rem = 1'b1;
                            end else begin
                                status_next = ST_NOT_FOUND;
                                state_next  = S_DONE;
                            end
                        end
                        default: begin
                            status_next = hit_reg ? ST_OK : ST_NOT_FOUND;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end
            S_SCMP: begin
                if (key_reg < mem_rd_data) begin
                    hip_next = mid_reg;
                end else if (key_reg == mem_rd_data) begin
                    hit_next = 1'b1;
                    lo_next  = mid_reg;
                end else begin
                    lo_next = mid_reg + 1'b1;
                end
                state_next = S_SRD;
            end
            S_RDW: begin
                rkey_next  = mem_rd_data;
                state_next = S_DONE;
            end
            S_SHIFT: begin
                if (rd_act_reg) begin
                    mem_rd_addr    = rp_reg[AW-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = ins_reg ? rp_reg + 1'b1 : rp_reg - 1'b1;
                    if (ins_reg ? (rp_reg == ix_reg) : (rp_reg == count_reg - 1'b1)) begin
                        rd_act_next = 1'b0;
                    end else begin
                        rp_next = ins_reg ? rp_reg - 1'b1 : rp_reg + 1'b1;
                    end
                end else if (!pend_reg) begin
                    if (ins_reg) begin
                        state_next = S_PUT;
                    end else begin
                        count_next = count_reg - 1'b1;
                        state_next = S_DONE;
                    end
                end
            end
            S_PUT: begin
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // open a gap at tgt: move entries tgt..count-1 up by one, top first
        if (go_ins) begin
            ix_next  = tgt;
            ins_next = 1'b1;
            if (count_reg > tgt) begin
                rp_next     = count_reg - 1'b1;
                rd_act_next = 1'b1;
                state_next  = S_SHIFT;
            end else begin
                state_next = S_PUT;
            end
        end

        // close the gap at tgt: move entries above it down by one
        if (go_rem) begin
            ix_next  = tgt;
            ins_next = 1'b0;
            if ((tgt + 1'b1) < count_reg) begin
                rp_next     = tgt + 1'b1;
                rd_act_next = 1'b1;
                state_next  = S_SHIFT;
            end else begin
                count_next = count_reg - 1'b1;
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            rd_act_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_act_reg <= rd_act_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        dup_reg       <= dup_next;
        lo_reg        <= lo_next;
        hip_reg       <= hip_next;
        mid_reg       <= mid_next;
        hit_reg       <= hit_next;
        ins_reg       <= ins_next;
        ix_reg        <= ix_next;
        rp_reg        <= rp_next;
        pend_addr_reg <= pend_addr_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        idx_reg       <= idx_next;
        rkey_reg      <= rkey_next;
    end

    // shift writes land in the cycle after their reads; the new key lands last
    assign mem_wr_en   = pend_reg || (state_reg == S_PUT);
    assign mem_wr_addr = (state_reg == S_PUT) ? ix_reg[AW-1:0] : pend_addr_reg[AW-1:0];
    assign mem_wr_data = (state_reg == S_PUT) ? key_reg : mem_rd_data;

    assign res.status = status_reg;
    assign res.found  = found_reg;
    assign res.index  = IDX_W'(idx_reg);
    assign res.rkey   = KEY_IN_W'(rkey_reg);
    assign res.count  = IDX_W'(count_reg);

endmodule

// File: design/sorted_key_table.sv
// search: binary search over the stored entries, one memory read per probe; read: one memory read
// add: search, then move each entry above the slot up by one, top first, then write the new key
// delete: search, then move each entry above the match down by one; clear resets the entry count
// all moves go through the single memory port pair
// one item is worked at a time; a new word is taken once the previous result is registered
// reset clears the entry count and the sequencer; the key memory is left as is
module sorted_key_table #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF,
    parameter int KEY_W    = skt_pkg::KEY_W_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [skt_pkg::S_TDATA_W-1:0] s_tdata,  // key, position, allow_dup, zero pad
    input  logic [skt_pkg::OPC_W-1:0]     s_tuser,  // opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [skt_pkg::M_TDATA_W-1:0] m_tdata,  // found, result_index, read_key, entry_count
    output logic [skt_pkg::STAT_W-1:0]    m_tuser   // status
);

    import skt_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int SK_W = (KEY_W < KEY_IN_W) ? KEY_W : KEY_IN_W;

    skt_item_t item;
    skt_res_t  res;
    logic      res_valid, res_ready;

    logic            mem_wr_en;
    logic [AW-1:0]   mem_wr_addr, mem_rd_addr;
    logic [SK_W-1:0] mem_wr_data, mem_rd_data;

    logic     out_valid_reg;
    skt_res_t out_reg;

    assign item.op  = s_tuser;
    assign item.key = s_tdata[KEY_IN_W-1:0];
    assign item.pos = s_tdata[KEY_IN_W +: POS_W];
    assign item.dup = s_tdata[KEY_IN_W + POS_W];

    skt_ctrl #(
        .CAPACITY (CAPACITY),
        .KEY_W    (KEY_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (s_tvalid),
        .item        (item),
        .item_ready  (s_tready),
        .res_valid   (res_valid),
        .res         (res),
        .res_ready   (res_ready),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    skt_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (SK_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // output word register
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {5'b0, out_reg.count, out_reg.rkey, out_reg.index, out_reg.found};

endmodule

// File: design/skt_chk.sv
// port-level checks for the sorted key table, bound to the top level
module skt_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [skt_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [skt_pkg::OPC_W-1:0]     s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [skt_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [skt_pkg::STAT_W-1:0]    m_tuser
);

    import skt_pkg::*;

    // no result word right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word present after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // one item in flight: an accepted word blocks the next cycle
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken in back-to-back cycles");

    a_miss_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_NOT_FOUND) |-> !m_tdata[0])
        else $error("not-found status with found flag set");

    a_dup_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_DUP) |-> m_tdata[0])
        else $error("duplicate refusal without a match");

    logic unused_in;
    assign unused_in = s_tvalid ^ (^s_tdata) ^ (^s_tuser);

endmodule

bind sorted_key_table skt_chk u_skt_chk (.*);

// File: tb/sv/tb_top.sv
// self-checking testbench for the sorted key table: directed plan, then random phases
`timescale 1ns / 100ps

module tb_top;
    import skt_pkg::*;

    localparam int CAPACITY   = CAPACITY_DEF;
    localparam int RAND_ITEMS = 1900;
    localparam int TAIL_WAIT  = 300;
    localparam int PLAN_ROWS  = 24;

    // opcodes the block leaves unused
    localparam logic [OPC_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OPC_W-1:0] OP_SPARE7 = 3'd7;

    localparam logic [$bits(skt_res_t):0] PREDICTED = '0;

    typedef enum int {MODE_MIXED, MODE_GROW, MODE_SHRINK, MODE_FILL} phase_mode_t;

    typedef struct packed {
        logic [OPC_W-1:0]    op;
        logic [KEY_IN_W-1:0] key;
        logic [POS_W-1:0]    pos;
        logic                dup;
        logic                typed;
        skt_res_t            want;
    } plan_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [OPC_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]    m_tuser;

    // mirror of the table contents
    logic [KEY_IN_W-1:0] key_mirror [CAPACITY];
    int                  mirror_count = 0;

    skt_res_t  expected_results [$];
    plan_row_t plan [PLAN_ROWS];
    int        mismatches = 0;
    bit        calm       = 1'b0;
    int        sink_wait  = 0;
    int        sink_gap;
    skt_res_t  got;

    sorted_key_table uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // binary search with the block's exact midpoint walk; where gets the final lo
    function automatic bit locate_key(input logic [KEY_IN_W-1:0] k, output int where);
        int lo;
        int hi;
        int md;
        int rc;
        lo = 0;
        hi = mirror_count - 1;
        rc = -1;
        while (rc != 0 && hi >= 0 && lo <= hi) begin
            md = lo + (hi - lo) / 2;
            if (k < key_mirror[md]) begin
                rc = -1;
                hi = md - 1;
            end else if (k == key_mirror[md]) begin
                rc = 0;
                lo = md;
            end else begin
                rc = 1;
                lo = md + 1;
            end
        end
        where = lo;
        return rc == 0;
    endfunction

    function automatic void insert_key(input int ix, input logic [KEY_IN_W-1:0] k);
        for (int i = mirror_count; i > ix; i--)
            key_mirror[i] = key_mirror[i-1];
        key_mirror[ix] = k;
        mirror_count++;
    endfunction

    function automatic void drop_key(input int ix);
        for (int i = ix; i + 1 < mirror_count; i++)
            key_mirror[i] = key_mirror[i+1];
        mirror_count--;
    endfunction

    // applies one operation to the mirror and returns the result word it should give
    function automatic skt_res_t table_op(input logic [OPC_W-1:0] op,
                                          input logic [KEY_IN_W-1:0] k,
                                          input logic [POS_W-1:0] p, input logic d);
        skt_res_t r;
        int       ix;
        bit       hit;
        r = '0;
        ix = 0;
        case (op)
            OP_ADD: begin
                if (mirror_count == 0) begin
                    insert_key(0, k);
                end else begin
                    hit = locate_key(k, ix);
                    r.found = hit;
                    r.index = ix[IDX_W-1:0];
                    if (hit && !d)
                        r.status = ST_DUP;
                    else if (mirror_count >= CAPACITY)
                        r.status = ST_FULL;
                    else
                        insert_key(ix, k);
                end
            end
            OP_DELETE: begin
                hit = locate_key(k, ix);
                r.found = hit;
                r.index = ix[IDX_W-1:0];
                if (hit)
                    drop_key(ix);
                else
                    r.status = ST_NOT_FOUND;
            end
            OP_SEARCH: begin
                hit = locate_key(k, ix);
                r.found = hit;
                r.index = ix[IDX_W-1:0];
                r.status = hit ? ST_OK : ST_NOT_FOUND;
            end
            OP_READ: begin
                if (int'(p) < mirror_count) begin
                    r.rkey = key_mirror[p];
                    r.index = {1'b0, p};
                end else begin
                    r.status = ST_BAD_INDEX;
                end
            end
            OP_REMOVE: begin
                if (int'(p) < mirror_count) begin
                    drop_key(int'(p));
                    r.index = {1'b0, p};
                end else begin
                    r.status = ST_BAD_INDEX;
                end
            end
            OP_CLEAR: mirror_count = 0;
            default: ;
        endcase
        r.count = mirror_count[IDX_W-1:0];
        return r;
    endfunction

    function automatic logic [KEY_IN_W-1:0] pick_key();
        int sel;
        int ix;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        if (sel <= 4 && mirror_count > 0) begin
            // near or on a stored key so hits and neighbors both show up
            ix = $urandom_range(0, mirror_count - 1);
            return key_mirror[ix] + KEY_IN_W'($urandom_range(0, 2)) - 32'd1;
        end
        if (sel <= 6)
            return KEY_IN_W'($urandom_range(0, 63));
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        if ($urandom_range(0, 4) == 0)
            return POS_W'($urandom_range(0, 255));
        return POS_W'($urandom_range(0, mirror_count > 255 ? 255 : mirror_count));
    endfunction

    function automatic logic [OPC_W-1:0] pick_op(input phase_mode_t mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_GROW: begin
                if (r < 60) return OP_ADD;
                if (r < 75) return OP_SEARCH;
                if (r < 90) return OP_READ;
                if (r < 95) return OP_DELETE;
                return OP_REMOVE;
            end
            MODE_SHRINK: begin
                if (r < 34) return OP_DELETE;
                if (r < 64) return OP_REMOVE;
                if (r < 79) return OP_SEARCH;
                if (r < 94) return OP_READ;
                if (r < 99) return OP_ADD;
                return OP_CLEAR;
            end
            MODE_FILL: return OP_ADD;
            default: begin
                if (r < 30) return OP_ADD;
                if (r < 50) return OP_DELETE;
                if (r < 69) return OP_SEARCH;
                if (r < 84) return OP_READ;
                if (r < 99) return OP_REMOVE;
                return OP_CLEAR;
            end
        endcase
    endfunction

    task automatic send_word(input logic [OPC_W-1:0] op, input logic [KEY_IN_W-1:0] k,
                             input logic [POS_W-1:0] p, input logic d,
                             input bit typed, input skt_res_t want);
        int       gap;
        skt_res_t pred;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, d, p, k};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        pred = table_op(op, k, p, d);
        expected_results.push_back(typed ? want : pred);
    endtask

    // result side: random stall before each word, compare against the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_wait <= 0;
        end else if (m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.found  = m_tdata[0];
            got.index  = m_tdata[9:1];
            got.rkey   = m_tdata[41:10];
            got.count  = m_tdata[50:42];
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected: status %0d count %0d",
                       got.status, got.count);
                mismatches++;
            end else begin
                skt_res_t exp_w;
                exp_w = expected_results.pop_front();
                if (got.status !== exp_w.status) begin
                    $error("status expected %0d got %0d", exp_w.status, got.status);
                    mismatches++;
                end
                if (got.found !== exp_w.found) begin
                    $error("found expected %0d got %0d", exp_w.found, got.found);
                    mismatches++;
                end
                if (got.index !== exp_w.index) begin
                    $error("result_index expected %0d got %0d", exp_w.index, got.index);
                    mismatches++;
                end
                if (got.rkey !== exp_w.rkey) begin
                    $error("read_key expected %h got %h", exp_w.rkey, got.rkey);
                    mismatches++;
                end
                if (got.count !== exp_w.count) begin
                    $error("entry_count expected %0d got %0d", exp_w.count, got.count);
                    mismatches++;
                end
            end
            sink_gap = calm ? 0 : $urandom_range(0, 5);
            sink_wait <= sink_gap;
            m_tready <= (sink_gap == 0);
        end else if (sink_wait > 0) begin
            sink_wait <= sink_wait - 1;
            m_tready <= (sink_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        int          sent;
        int          seg;
        int          seg_len;
        int          tail;
        phase_mode_t mode;
        logic [KEY_IN_W-1:0] k;

        plan[0]  = {OP_SEARCH, 32'h0000_0005, 8'h00, 1'b0, 1'b1,
                    ST_NOT_FOUND, 1'b0, 9'd0, 32'd0, 9'd0};
        plan[1]  = {OP_READ,   32'h0000_0000, 8'h00, 1'b0, 1'b1,
                    ST_BAD_INDEX, 1'b0, 9'd0, 32'd0, 9'd0};
        plan[2]  = {OP_REMOVE, 32'h0000_0000, 8'h00, 1'b0, 1'b1,
                    ST_BAD_INDEX, 1'b0, 9'd0, 32'd0, 9'd0};
        plan[3]  = {OP_DELETE, 32'h0000_0005, 8'h00, 1'b0, 1'b1,
                    ST_NOT_FOUND, 1'b0, 9'd0, 32'd0, 9'd0};
        plan[4]  = {OP_ADD,    32'h0000_0000, 8'h00, 1'b0, 1'b1,
                    ST_OK, 1'b0, 9'd0, 32'd0, 9'd1};
        plan[5]  = {OP_ADD,    32'hFFFF_FFFF, 8'h00, 1'b0, PREDICTED};
        plan[6]  = {OP_ADD,    32'h0000_0000, 8'h00, 1'b0, 1'b1,
                    ST_DUP, 1'b1, 9'd0, 32'd0, 9'd2};
        plan[7]  = {OP_ADD,    32'h0000_0000, 8'h00, 1'b1, PREDICTED};
        plan[8]  = {OP_ADD,    32'h8000_0000, 8'h00, 1'b0, PREDICTED};
        plan[9]  = {OP_SEARCH, 32'hFFFF_FFFF, 8'h00, 1'b0, PREDICTED};
        plan[10] = {OP_SEARCH, 32'h7FFF_FFFF, 8'h00, 1'b0, PREDICTED};
        plan[11] = {OP_READ,   32'h0000_0000, 8'h00, 1'b0, PREDICTED};
        plan[12] = {OP_READ,   32'h0000_0000, 8'hFF, 1'b0, PREDICTED};
        plan[13] = {OP_REMOVE, 32'h0000_0000, 8'h01, 1'b0, PREDICTED};
        plan[14] = {OP_DELETE, 32'hFFFF_FFFF, 8'h00, 1'b0, PREDICTED};
        plan[15] = {OP_DELETE, 32'h1234_5678, 8'h00, 1'b0, PREDICTED};
        plan[16] = {OP_SPARE6, 32'hFFFF_FFFF, 8'hFF, 1'b1, PREDICTED};
        plan[17] = {OP_SPARE7, 32'h0000_0000, 8'h00, 1'b0, PREDICTED};
        plan[18] = {OP_READ,   32'h0000_0000, 8'h01, 1'b0, PREDICTED};
        plan[19] = {OP_CLEAR,  32'h0000_0000, 8'h00, 1'b0, 1'b1,
                    ST_OK, 1'b0, 9'd0, 32'd0, 9'd0};
        plan[20] = {OP_READ,   32'h0000_0000, 8'h00, 1'b0, 1'b1,
                    ST_BAD_INDEX, 1'b0, 9'd0, 32'd0, 9'd0};
        plan[21] = {OP_ADD,    32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1,
                    ST_OK, 1'b0, 9'd0, 32'd0, 9'd1};
        plan[22] = {OP_SEARCH, 32'hAAAA_AAAA, 8'hFF, 1'b1, PREDICTED};
        plan[23] = {OP_DELETE, 32'hFFFF_FFFF, 8'hFF, 1'b1, PREDICTED};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++)
            send_word(plan[i].op, plan[i].key, plan[i].pos, plan[i].dup,
                      plan[i].typed, plan[i].want);

        sent = 0;
        seg = 0;
        while (sent < RAND_ITEMS) begin
            seg++;
            calm = ($urandom_range(0, 3) == 0);
            if (seg == 2) begin
                mode = MODE_FILL;
            end else begin
                case ($urandom_range(0, 2))
                    0: mode = MODE_GROW;
                    1: mode = MODE_SHRINK;
                    default: mode = MODE_MIXED;
                endcase
            end
            if (mode == MODE_FILL) begin
                // fill to capacity, then a few more adds that must be refused
                tail = 8;
                while (mirror_count < CAPACITY || tail > 0) begin
                    if (mirror_count >= CAPACITY)
                        tail--;
                    k = ($urandom_range(0, 7) == 0) ? pick_key() : $urandom;
                    send_word(OP_ADD, k, pick_pos(), 1'($urandom_range(0, 1)), 1'b0, '0);
                    sent++;
                end
            end else begin
                seg_len = $urandom_range(40, 160);
                for (int j = 0; j < seg_len && sent < RAND_ITEMS; j++) begin
                    send_word(pick_op(mode), pick_key(), pick_pos(),
                              1'($urandom_range(0, 1)), 1'b0, '0);
                    sent++;
                end
            end
        end

        s_tvalid <= 1'b0;
        calm = 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
design/skt_pkg.sv
design/skt_mem.sv
design/skt_ctrl.sv
design/sorted_key_table.sv
design/skt_chk.sv
tb/sv/tb_top.sv
